>>> rtl/core/assert_macros.svh
// assertion helper macros used by the decoder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_CLK(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(name, clk, rst_n, prop, msg)
`define ASSERT_NEVER(name, clk, rst_n, cond, msg)
`endif
`endif

>>> rtl/core/ppmd_pkg.sv
// types, codes and character constants for the ppm stream decoder
`timescale 1ns / 1ps
package ppmd_pkg;

    // parser phases
    typedef enum logic [3:0] {
        PH_MAGIC0 = 4'd0,
        PH_MAGIC1 = 4'd1,
        PH_WIDTH  = 4'd2,
        PH_HEIGHT = 4'd3,
        PH_MAXVAL = 4'd4,
        PH_ASCII  = 4'd5,
        PH_RAW    = 4'd6,
        PH_DONE   = 4'd7
    } t_phase;

    // result kinds
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_PIXEL  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // error codes
    localparam logic [2:0] ERR_NONE   = 3'd0;
    localparam logic [2:0] ERR_MAGIC  = 3'd1;
    localparam logic [2:0] ERR_HEADER = 3'd2;
    localparam logic [2:0] ERR_RASTER = 3'd3;
    localparam logic [2:0] ERR_TRUNC  = 3'd4;

    // characters
    localparam logic [7:0] CH_P    = 8'h50;
    localparam logic [7:0] CH_3    = 8'h33;
    localparam logic [7:0] CH_6    = 8'h36;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_VT   = 8'h0B;
    localparam logic [7:0] CH_FF   = 8'h0C;
    localparam logic [7:0] CH_CR   = 8'h0D;

    // header limits
    localparam logic [16:0] MAX_DIM    = 17'd65535;
    localparam logic [16:0] MAX_SAMPLE = 17'd255;
    localparam logic [16:0] NUM_SAT    = 17'd131071;

    // input word
    typedef struct packed {
        logic [7:0] file_byte;
        logic       end_of_file;
    } t_in_word;

    // result word
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] width;
        logic [15:0] height;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [2:0]  error_code;
        logic        last;
    } t_out_word;

    // parser state
    typedef struct packed {
        t_phase      phase;
        logic        binary_mode;
        logic        in_comment;
        logic [16:0] number_value;
        logic        number_has_digit;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [15:0] column_count;
        logic [15:0] row_count;
        logic [1:0]  channel_index;
        logic [7:0]  held_red;
        logic [7:0]  held_green;
    } t_parse_state;

    localparam t_parse_state PARSE_CLEAR = '{
        phase:            PH_MAGIC0,
        binary_mode:      1'b0,
        in_comment:       1'b0,
        number_value:     17'd0,
        number_has_digit: 1'b0,
        image_width:      16'd0,
        image_height:     16'd0,
        column_count:     16'd0,
        row_count:        16'd0,
        channel_index:    2'd0,
        held_red:         8'd0,
        held_green:       8'd0
    };

    // error result word
    function automatic t_out_word error_word(logic [2:0] code);
        t_out_word w;
        w            = '0;
        w.kind       = KIND_ERROR;
        w.error_code = code;
        w.last       = 1'b1;
        return w;
    endfunction

endpackage

>>> rtl/core/ppmd_parser.sv
// byte parser: header, comments, number tokens and pixel assembly
`timescale 1ns / 1ps
module ppmd_parser
    import ppmd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  t_in_word   i_word,
    input  logic       i_clear_black,
    output logic [1:0] o_count,
    output t_out_word  o_res0,
    output t_out_word  o_res1
);

    typedef struct packed {
        t_parse_state st;
        logic         emit;
        t_out_word    word;
    } t_nd_ret;

    // one sample into the pixel, emits on the third channel
    function automatic t_nd_ret take_sample(t_parse_state s, logic [7:0] v, logic bta);
        t_nd_ret     r;
        logic [15:0] cc;
        logic [15:0] rc;
        r      = '0;
        cc     = '0;
        rc     = '0;
        case (s.channel_index)
            2'd0: begin
                s.held_red      = v;
                s.channel_index = 2'd1;
            end
            2'd1: begin
                s.held_green    = v;
                s.channel_index = 2'd2;
            end
            default: begin
                s.channel_index = 2'd0;
                r.emit          = 1'b1;
                r.word.kind     = KIND_PIXEL;
                r.word.red      = s.held_red;
                r.word.green    = s.held_green;
                r.word.blue     = v;
                r.word.alpha    = (bta && s.held_red == 8'd0 && s.held_green == 8'd0
                                   && v == 8'd0) ? 8'd0 : 8'd255;
                cc = s.column_count + 16'd1;
                if (cc >= s.image_width) begin
                    cc = 16'd0;
                    rc = s.row_count + 16'd1;
                    s.row_count = rc;
                    if (rc >= s.image_height) begin
                        r.word.last = 1'b1;
                        s.phase     = PH_DONE;
                    end
                end
                s.column_count = cc;
            end
        endcase
        r.st = s;
        return r;
    endfunction

    // close a digit run and act on the number
    function automatic t_nd_ret number_done(t_parse_state s, logic bta);
        t_nd_ret     r;
        logic [16:0] v;
        r                  = '0;
        v                  = s.number_value;
        s.number_value     = 17'd0;
        s.number_has_digit = 1'b0;
        case (s.phase)
            PH_WIDTH, PH_HEIGHT: begin
                if (v == 17'd0 || v > MAX_DIM) begin
                    r.emit  = 1'b1;
                    r.word  = error_word(ERR_HEADER);
                    s.phase = PH_DONE;
                end else if (s.phase == PH_WIDTH) begin
                    s.image_width = v[15:0];
                    s.phase       = PH_HEIGHT;
                end else begin
                    s.image_height = v[15:0];
                    s.phase        = PH_MAXVAL;
                end
                r.st = s;
            end
            PH_MAXVAL: begin
                if (v == 17'd0 || v > MAX_SAMPLE) begin
                    r.emit  = 1'b1;
                    r.word  = error_word(ERR_HEADER);
                    s.phase = PH_DONE;
                end else begin
                    r.emit          = 1'b1;
                    r.word.kind     = KIND_HEADER;
                    r.word.width    = s.image_width;
                    r.word.height   = s.image_height;
                    s.column_count  = 16'd0;
                    s.row_count     = 16'd0;
                    s.channel_index = 2'd0;
                    s.phase         = s.binary_mode ? PH_RAW : PH_ASCII;
                end
                r.st = s;
            end
            PH_ASCII: begin
                r = take_sample(s, v[7:0], bta);
            end
            default: begin
                r.st = s;
            end
        endcase
        return r;
    endfunction

    t_parse_state r_state;
    t_parse_state n_state;
    t_nd_ret      w_nd_tok;
    t_nd_ret      w_nd_eof;
    logic [1:0]   w_cnt;
    t_out_word    w_res0;
    t_out_word    w_res1;
    logic         w_raster;
    logic         w_stop;
    logic [20:0]  w_nv;
    logic [7:0]   w_c;

    assign w_c = i_word.file_byte;

    // one byte through the parser
    always_comb begin
        n_state  = r_state;
        w_cnt    = 2'd0;
        w_res0   = '0;
        w_res1   = '0;
        w_nd_tok = '0;
        w_nd_eof = '0;
        w_raster = 1'b0;
        w_stop   = 1'b0;
        w_nv     = '0;
        case (n_state.phase)
            PH_MAGIC0: begin
                if (w_c == CH_P) begin
                    n_state.phase = PH_MAGIC1;
                end else begin
                    n_state.phase = PH_DONE;
                    w_res0        = error_word(ERR_MAGIC);
                    w_cnt         = 2'd1;
                end
            end
            PH_MAGIC1: begin
                if (w_c == CH_3 || w_c == CH_6) begin
                    n_state.binary_mode = (w_c == CH_6);
                    n_state.phase       = PH_WIDTH;
                end else begin
                    n_state.phase = PH_DONE;
                    w_res0        = error_word(ERR_MAGIC);
                    w_cnt         = 2'd1;
                end
            end
            PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_ASCII: begin
                w_raster = (n_state.phase == PH_ASCII);
                if (n_state.in_comment) begin
                    if (w_c == CH_LF) begin
                        n_state.in_comment = 1'b0;
                    end
                end else if (w_c inside {[CH_ZERO:CH_NINE]}) begin
                    // value times ten plus digit
                    w_nv = {n_state.number_value, 3'b000} + {2'b00, n_state.number_value, 1'b0}
                         + {13'd0, w_c - CH_ZERO};
                    if (w_raster) begin
                        n_state.number_value = {9'd0, w_nv[7:0]};
                    end else if (w_nv > {4'd0, NUM_SAT}) begin
                        n_state.number_value = NUM_SAT;
                    end else begin
                        n_state.number_value = w_nv[16:0];
                    end
                    n_state.number_has_digit = 1'b1;
                end else begin
                    // the byte ends a digit run
                    if (n_state.number_has_digit) begin
                        w_nd_tok = number_done(n_state, i_clear_black);
                        n_state  = w_nd_tok.st;
                        if (w_nd_tok.emit) begin
                            w_res0 = w_nd_tok.word;
                            w_cnt  = 2'd1;
                        end
                        w_stop   = (n_state.phase == PH_RAW) || (n_state.phase == PH_DONE);
                        w_raster = (n_state.phase == PH_ASCII);
                    end
                    if (!w_stop) begin
                        if (w_c inside {CH_SP, CH_TAB, CH_LF, CH_CR, CH_VT, CH_FF}) begin
                            n_state.in_comment = 1'b0;
                        end else if (w_c == CH_HASH) begin
                            n_state.in_comment = 1'b1;
                        end else begin
                            n_state.phase = PH_DONE;
                            if (w_cnt == 2'd0) begin
                                w_res0 = error_word(w_raster ? ERR_RASTER : ERR_HEADER);
                            end else begin
                                w_res1 = error_word(w_raster ? ERR_RASTER : ERR_HEADER);
                            end
                            w_cnt = w_cnt + 2'd1;
                        end
                    end
                end
            end
            PH_RAW: begin
                w_nd_tok = take_sample(n_state, w_c, i_clear_black);
                n_state  = w_nd_tok.st;
                if (w_nd_tok.emit) begin
                    w_res0 = w_nd_tok.word;
                    w_cnt  = 2'd1;
                end
            end
            default: begin
                n_state = r_state;
            end
        endcase

        // end of file: flush a pending number, report truncation, start over
        if (i_word.end_of_file) begin
            if ((n_state.phase inside {PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_ASCII})
                && n_state.number_has_digit) begin
                w_nd_eof = number_done(n_state, i_clear_black);
                n_state  = w_nd_eof.st;
                if (w_nd_eof.emit) begin
                    if (w_cnt == 2'd0) begin
                        w_res0 = w_nd_eof.word;
                    end else begin
                        w_res1 = w_nd_eof.word;
                    end
                    w_cnt = w_cnt + 2'd1;
                end
            end
            if (n_state.phase != PH_DONE) begin
                if (w_cnt == 2'd0) begin
                    w_res0 = error_word(ERR_TRUNC);
                end else begin
                    w_res1 = error_word(ERR_TRUNC);
                end
                w_cnt = w_cnt + 2'd1;
            end
            n_state = PARSE_CLEAR;
        end
    end

    // parser state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PARSE_CLEAR;
        end else if (i_step) begin
            r_state <= n_state;
        end
    end

    assign o_count = i_step ? w_cnt : 2'd0;
    assign o_res0  = w_res0;
    assign o_res1  = w_res1;

endmodule

>>> rtl/core/ppmd_out_fifo.sv
// result queue: takes up to two words a cycle, gives one unless i_stall is set
`timescale 1ns / 1ps
module ppmd_out_fifo
    import ppmd_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_push_cnt,
    input  t_out_word  i_push0,
    input  t_out_word  i_push1,
    output logic       o_room2,
    output logic       o_valid,
    input  logic       i_stall,
    output t_out_word  o_word
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_out_word         r_mem [DEPTH];
    logic [AW-1:0]     r_wr_ptr;
    logic [AW-1:0]     r_rd_ptr;
    logic [CW-1:0]     r_count;
    logic [AW-1:0]     w_wr1;
    logic [AW-1:0]     n_wr_ptr;
    logic              w_pop;

    function automatic logic [AW-1:0] next_ptr(logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign w_wr1 = next_ptr(r_wr_ptr);
    assign w_pop = (r_count != '0) && !i_stall;

    // write pointer advance
    always_comb begin
        case (i_push_cnt)
            2'd0:    n_wr_ptr = r_wr_ptr;
            2'd1:    n_wr_ptr = w_wr1;
            default: n_wr_ptr = next_ptr(w_wr1);
        endcase
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[w_wr1] <= i_push1;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            if (w_pop) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
            r_count <= r_count + CW'(i_push_cnt) - CW'(w_pop);
        end
    end

    assign o_room2 = (r_count <= CW'(DEPTH - 2));
    assign o_valid = (r_count != '0);
    assign o_word  = r_mem[r_rd_ptr];

endmodule

>>> rtl/core/ppm_stream_decoder_core.sv
// Streaming PPM (P3/P6) decoder: one file byte per word in, header, RGBA pixel
// and error words out. A byte is registered on acceptance, parsed from that
// register once the result queue of OUT_DEPTH words has room for two words,
// and its results (none, one or two) are pushed into that queue. One byte is
// taken per cycle as long as the queue has room for two words; the queue
// drains one word per cycle while i_out_stall is low, so the two results of
// one byte (e.g. a pixel on the end-of-file byte of an incomplete raster and
// its truncation error) leave the queue one after the other. The
// transparent-black flag is written through i_cfg_wr_en/i_cfg_wr_data by
// the user only between files (not enforced) and survives the end of a file.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ppm_stream_decoder_core
    import ppmd_pkg::*;
#(
    parameter int OUT_DEPTH = 4
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_wr_en,
    input  logic      i_cfg_wr_data,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    logic       r_clear_black;
    logic       r_in_valid;
    t_in_word   r_in_word;
    logic       w_room2;
    logic       w_step;
    logic [1:0] w_res_cnt;
    t_out_word  w_res0;
    t_out_word  w_res1;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clear_black <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_clear_black <= i_cfg_wr_data;
        end
    end

    // input register
    assign w_step     = r_in_valid && w_room2;
    assign o_in_stall = r_in_valid && !w_room2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_word <= i_in_word;
        end
    end

    // parser
    ppmd_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_step),
        .i_word        (r_in_word),
        .i_clear_black (r_clear_black),
        .o_count       (w_res_cnt),
        .o_res0        (w_res0),
        .o_res1        (w_res1)
    );

    // result queue
    ppmd_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (w_res_cnt),
        .i_push0    (w_res0),
        .i_push1    (w_res1),
        .o_room2    (w_room2),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_word     (o_out_word)
    );

    // checks
    `ASSERT_CLK(a_in_hold, i_clk, i_rst_n, r_in_valid && !w_step |=> r_in_valid && $stable(r_in_word), "held byte lost")
    `ASSERT_NEVER(a_no_idle_result, i_clk, i_rst_n, !w_step && (w_res_cnt != 2'd0), "result without a byte")
    `ASSERT_CLK(a_error_last, i_clk, i_rst_n, o_out_valid && (o_out_word.kind == KIND_ERROR) |-> o_out_word.last, "error word without last")

endmodule
